// ===== rtl/cpwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpwm_pkg
// Shared types and constants of the charge and drive PWM regulator.
// ----------------------------------------------------------------------------
package cpwm_pkg;

    localparam int SENSE_BITS_DEF = 12;
    localparam int THRESH_BITS    = 12;
    localparam int HOLD_BITS      = 8;
    localparam int DUTY_BITS      = 6;
    localparam int TIMER_BITS     = 12;
    localparam int LEVEL_BITS     = 5;
    localparam int PWM_BITS       = 7;
    localparam int APB_ADDR_BITS  = 5;
    localparam int APB_DATA_BITS  = 32;

    // register reset values
    localparam logic [THRESH_BITS-1:0] CURRENT_LOW_RST  = 12'd70;
    localparam logic [THRESH_BITS-1:0] CURRENT_HIGH_RST = 12'd80;
    localparam logic [THRESH_BITS-1:0] BATT_FULL_RST    = 12'd1555;
    localparam logic [HOLD_BITS-1:0]   STEP_HOLD_RST    = 8'd10;
    localparam logic [DUTY_BITS-1:0]   DUTY_MAX_RST     = 6'd35;
    localparam logic [DUTY_BITS-1:0]   DUTY_MIN_RST     = 6'd10;
    localparam logic [TIMER_BITS-1:0]  FULL_TIME_RST    = 12'd2500;

    // PWM shaping
    localparam logic [PWM_BITS-1:0]   PERIOD_MOTOR   = 7'd100;
    localparam logic [PWM_BITS-1:0]   PERIOD_CHARGE  = 7'd70;
    localparam logic [PWM_BITS-1:0]   PERIOD_OFF     = 7'd0;
    localparam logic [PWM_BITS-1:0]   DUTY_LOW_BASE  = 7'd50;
    localparam logic [PWM_BITS-1:0]   DUTY_HIGH_BASE = 7'd40;
    localparam logic [LEVEL_BITS-1:0] LEVEL_KNEE     = 5'd10;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_MOTOR  = 2'd1,
        MODE_CHARGE = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        REG_CURRENT_LOW  = 3'd0,
        REG_CURRENT_HIGH = 3'd1,
        REG_BATT_FULL    = 3'd2,
        REG_STEP_HOLD    = 3'd3,
        REG_DUTY_MAX     = 3'd4,
        REG_DUTY_MIN     = 3'd5,
        REG_FULL_TIME    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [THRESH_BITS-1:0] current_low;
        logic [THRESH_BITS-1:0] current_high;
        logic [THRESH_BITS-1:0] battery_full_level;
        logic [HOLD_BITS-1:0]   step_hold;
        logic [DUTY_BITS-1:0]   duty_max;
        logic [DUTY_BITS-1:0]   duty_min;
        logic [TIMER_BITS-1:0]  full_time;
    } t_cfg;

    typedef struct packed {
        t_mode               drive_mode;
        logic [PWM_BITS-1:0] pwm_period;
        logic [PWM_BITS-1:0] pwm_duty;
        logic                charge_active;
        logic                charge_full;
    } t_result;

endpackage

// ===== rtl/cpwm_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpwm_ifs
// Valid/ready channels for tick items and PWM result items.
// ----------------------------------------------------------------------------
interface cpwm_in_if #(
    parameter int SENSE_BITS = cpwm_pkg::SENSE_BITS_DEF
) ();
    logic                              valid;
    logic                              ready;
    logic                              charger_present;
    logic [SENSE_BITS-1:0]             charge_sense;
    logic [SENSE_BITS-1:0]             battery_sense;
    logic [cpwm_pkg::LEVEL_BITS-1:0]   drive_level;

    modport source (
        output valid, charger_present, charge_sense, battery_sense, drive_level,
        input  ready
    );
    modport sink (
        input  valid, charger_present, charge_sense, battery_sense, drive_level,
        output ready
    );
endinterface

interface cpwm_out_if ();
    logic                            valid;
    logic                            ready;
    logic [1:0]                      drive_mode;
    logic [cpwm_pkg::PWM_BITS-1:0]   pwm_period;
    logic [cpwm_pkg::PWM_BITS-1:0]   pwm_duty;
    logic                            charge_active;
    logic                            charge_full;

    modport source (
        output valid, drive_mode, pwm_period, pwm_duty, charge_active, charge_full,
        input  ready
    );
    modport sink (
        input  valid, drive_mode, pwm_period, pwm_duty, charge_active, charge_full,
        output ready
    );
endinterface

// ===== rtl/cpwm_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpwm_cfg
// APB register file holding the regulator thresholds and timing.
// ----------------------------------------------------------------------------
module cpwm_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cpwm_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [cpwm_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [cpwm_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output cpwm_pkg::t_cfg                      o_cfg
);

    cpwm_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.current_low        <= cpwm_pkg::CURRENT_LOW_RST;
            r_cfg.current_high       <= cpwm_pkg::CURRENT_HIGH_RST;
            r_cfg.battery_full_level <= cpwm_pkg::BATT_FULL_RST;
            r_cfg.step_hold          <= cpwm_pkg::STEP_HOLD_RST;
            r_cfg.duty_max           <= cpwm_pkg::DUTY_MAX_RST;
            r_cfg.duty_min           <= cpwm_pkg::DUTY_MIN_RST;
            r_cfg.full_time          <= cpwm_pkg::FULL_TIME_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                cpwm_pkg::REG_CURRENT_LOW:
                    r_cfg.current_low <= pwdata[cpwm_pkg::THRESH_BITS-1:0];
                cpwm_pkg::REG_CURRENT_HIGH:
                    r_cfg.current_high <= pwdata[cpwm_pkg::THRESH_BITS-1:0];
                cpwm_pkg::REG_BATT_FULL:
                    r_cfg.battery_full_level <= pwdata[cpwm_pkg::THRESH_BITS-1:0];
                cpwm_pkg::REG_STEP_HOLD:
                    r_cfg.step_hold <= pwdata[cpwm_pkg::HOLD_BITS-1:0];
                cpwm_pkg::REG_DUTY_MAX:
                    r_cfg.duty_max <= pwdata[cpwm_pkg::DUTY_BITS-1:0];
                cpwm_pkg::REG_DUTY_MIN:
                    r_cfg.duty_min <= pwdata[cpwm_pkg::DUTY_BITS-1:0];
                cpwm_pkg::REG_FULL_TIME:
                    r_cfg.full_time <= pwdata[cpwm_pkg::TIMER_BITS-1:0];
                default: ;  // unmapped: drop
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            cpwm_pkg::REG_CURRENT_LOW:
                prdata = cpwm_pkg::APB_DATA_BITS'(r_cfg.current_low);
            cpwm_pkg::REG_CURRENT_HIGH:
                prdata = cpwm_pkg::APB_DATA_BITS'(r_cfg.current_high);
            cpwm_pkg::REG_BATT_FULL:
                prdata = cpwm_pkg::APB_DATA_BITS'(r_cfg.battery_full_level);
            cpwm_pkg::REG_STEP_HOLD:
                prdata = cpwm_pkg::APB_DATA_BITS'(r_cfg.step_hold);
            cpwm_pkg::REG_DUTY_MAX:
                prdata = cpwm_pkg::APB_DATA_BITS'(r_cfg.duty_max);
            cpwm_pkg::REG_DUTY_MIN:
                prdata = cpwm_pkg::APB_DATA_BITS'(r_cfg.duty_min);
            cpwm_pkg::REG_FULL_TIME:
                prdata = cpwm_pkg::APB_DATA_BITS'(r_cfg.full_time);
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== rtl/cpwm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpwm_core
// Charger state, duty regulator and PWM selection for one tick item.
// ----------------------------------------------------------------------------
module cpwm_core #(
    parameter int SENSE_BITS = cpwm_pkg::SENSE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cpwm_pkg::t_cfg                    i_cfg,
    input  logic                              i_advance,
    input  logic                              i_present,
    input  logic [SENSE_BITS-1:0]             i_csense,
    input  logic [SENSE_BITS-1:0]             i_bsense,
    input  logic [cpwm_pkg::LEVEL_BITS-1:0]   i_level,
    output cpwm_pkg::t_result                 o_res
);

    localparam int CmpBits = (SENSE_BITS > cpwm_pkg::THRESH_BITS) ?
                             SENSE_BITS : cpwm_pkg::THRESH_BITS;
    localparam int HB = cpwm_pkg::HOLD_BITS;
    localparam int DB = cpwm_pkg::DUTY_BITS;
    localparam int TB = cpwm_pkg::TIMER_BITS;
    localparam int PB = cpwm_pkg::PWM_BITS;

    logic                  r_charging, r_full;
    logic [DB-1:0]         r_duty;
    logic [HB-1:0]         r_raise_hold, r_lower_hold;
    logic [TB-1:0]         r_timer;
    logic [SENSE_BITS-1:0] r_held_c, r_held_b;

    logic                  n_charging, n_full;
    logic [DB-1:0]         n_duty;
    logic [HB-1:0]         n_raise_hold, n_lower_hold;
    logic [TB-1:0]         n_timer;

    logic [CmpBits-1:0]    held_c, held_b, cur_low, cur_high, full_lvl, bsense;
    logic                  batt_over, raise_c, lower_c, raise_step, lower_step;
    logic                  charge_tick, new_over, timer_done;
    logic [HB-1:0]         raise_inc, lower_inc;
    logic [DB-1:0]         duty_up, duty_dn;
    logic [TB:0]           timer_inc;
    logic [PB-1:0]         motor_duty;

    always_comb begin
        held_c   = CmpBits'(r_held_c);
        held_b   = CmpBits'(r_held_b);
        bsense   = CmpBits'(i_bsense);
        cur_low  = CmpBits'(i_cfg.current_low);
        cur_high = CmpBits'(i_cfg.current_high);
        full_lvl = CmpBits'(i_cfg.battery_full_level);

        // regulator works on the samples held from the previous tick
        batt_over  = held_b > full_lvl;
        raise_c    = (held_c < cur_low) && !batt_over;
        lower_c    = (held_c > cur_high) || batt_over;
        raise_inc  = r_raise_hold + 1'b1;
        lower_inc  = r_lower_hold + 1'b1;
        raise_step = raise_c && (raise_inc > i_cfg.step_hold) && (r_duty < i_cfg.duty_max);
        duty_up    = raise_step ? r_duty + 1'b1 : r_duty;
        lower_step = lower_c && (lower_inc > i_cfg.step_hold) && (duty_up > i_cfg.duty_min);
        duty_dn    = lower_step ? duty_up - 1'b1 : duty_up;

        charge_tick = (i_level == '0) && r_charging && !r_full;

        new_over   = bsense > full_lvl;
        timer_inc  = {1'b0, r_timer} + 1'b1;
        timer_done = timer_inc > {1'b0, i_cfg.full_time};

        n_raise_hold = r_raise_hold;
        n_lower_hold = r_lower_hold;
        n_duty       = r_duty;
        if (charge_tick) begin
            n_raise_hold = (raise_c && !raise_step) ? raise_inc : '0;
            n_lower_hold = (lower_c && !lower_step) ? lower_inc : '0;
            n_duty       = duty_dn;
        end

        if (i_present) begin
            n_charging = 1'b1;
            n_full     = r_full;
            if (!new_over) begin
                n_timer = '0;
            end else if (timer_done) begin
                n_timer = '0;
                n_full  = 1'b1;
            end else begin
                n_timer = timer_inc[TB-1:0];
            end
        end else begin
            // unplugged: drop charge state
            n_charging = 1'b0;
            n_full     = 1'b0;
            n_timer    = '0;
            n_duty     = '0;
        end

        motor_duty = (i_level <= cpwm_pkg::LEVEL_KNEE) ?
                     cpwm_pkg::DUTY_LOW_BASE + PB'(i_level) :
                     cpwm_pkg::DUTY_HIGH_BASE + PB'({i_level, 1'b0});

        if (i_level != '0) begin
            o_res.drive_mode = cpwm_pkg::MODE_MOTOR;
            o_res.pwm_period = cpwm_pkg::PERIOD_MOTOR;
            o_res.pwm_duty   = motor_duty;
        end else if (charge_tick) begin
            o_res.drive_mode = cpwm_pkg::MODE_CHARGE;
            o_res.pwm_period = cpwm_pkg::PERIOD_CHARGE;
            o_res.pwm_duty   = PB'(duty_dn);
        end else begin
            o_res.drive_mode = cpwm_pkg::MODE_OFF;
            o_res.pwm_period = cpwm_pkg::PERIOD_OFF;
            o_res.pwm_duty   = '0;
        end
        o_res.charge_active = n_charging;
        o_res.charge_full   = n_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charging   <= 1'b0;
            r_full       <= 1'b0;
            r_duty       <= '0;
            r_raise_hold <= '0;
            r_lower_hold <= '0;
            r_timer      <= '0;
            r_held_c     <= '0;
            r_held_b     <= '0;
        end else if (i_advance) begin
            r_charging   <= n_charging;
            r_full       <= n_full;
            r_duty       <= n_duty;
            r_raise_hold <= n_raise_hold;
            r_lower_hold <= n_lower_hold;
            r_timer      <= n_timer;
            r_held_b     <= i_bsense;
            if (i_present) begin
                r_held_c <= i_csense;
            end
        end
    end

endmodule

// ===== rtl/charge_and_drive_pwm_regulator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charge_and_drive_pwm_regulator_top
// One tick item in, one PWM result item out: motor drive or charge regulation.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries one control tick (charger presence, charge and battery
//   samples, drive level) on a valid/ready channel. o_res returns one item
//   per tick: drive mode, PWM period and duty, charging and full flags.
//   Thresholds and timing sit in seven APB registers at byte addresses 4*i;
//   write them only while no item is in flight.
// Path: the result item is valid on o_res once its tick has passed the input
//   register and the result register; a stall on o_res holds it back.
// Throughput: one item per cycle while o_res is not stalled. The tick goes
//   through an input register, one pass of compare/count logic that also
//   updates the charger state, and a result register.
// Reset: synchronous, active low; clears the valid flags of both pipeline
//   registers, the charger state and held samples, and loads the register
//   defaults.
// Stall: while o_res is held off, the result register holds; one more item
//   waits in the input register, then i_item.ready drops.
// ----------------------------------------------------------------------------
module charge_and_drive_pwm_regulator_top #(
    parameter int SENSE_BITS = cpwm_pkg::SENSE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    cpwm_in_if.sink                             i_item,
    cpwm_out_if.source                          o_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cpwm_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [cpwm_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [cpwm_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    cpwm_pkg::t_cfg     cfg;
    cpwm_pkg::t_result  core_res;
    cpwm_pkg::t_result  r_out;

    logic                              r_in_valid, r_out_valid;
    logic                              r_in_present;
    logic [SENSE_BITS-1:0]             r_in_csense, r_in_bsense;
    logic [cpwm_pkg::LEVEL_BITS-1:0]   r_in_level;
    logic                              advance, in_fire;

    assign advance      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_item.ready = !r_in_valid || advance;
    assign in_fire      = i_item.valid && i_item.ready;

    cpwm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cpwm_core #(
        .SENSE_BITS (SENSE_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (advance),
        .i_present (r_in_present),
        .i_csense  (r_in_csense),
        .i_bsense  (r_in_bsense),
        .i_level   (r_in_level),
        .o_res     (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_present <= i_item.charger_present;
            r_in_csense  <= i_item.charge_sense;
            r_in_bsense  <= i_item.battery_sense;
            r_in_level   <= i_item.drive_level;
        end
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.drive_mode    = r_out.drive_mode;
    assign o_res.pwm_period    = r_out.pwm_period;
    assign o_res.pwm_duty      = r_out.pwm_duty;
    assign o_res.charge_active = r_out.charge_active;
    assign o_res.charge_full   = r_out.charge_full;

`ifndef NO_ASSERTIONS
    // full can only be reported while charging
    a_full_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.charge_full || r_out.charge_active))
        else $error("charge_full without charge_active");

    // a waiting item stays put while the result side is stalled
    a_hold_in_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_res.ready) |=> r_in_valid)
        else $error("input item dropped under stall");

    // charge drive only after a tick that left charging set
    a_charge_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && core_res.drive_mode == cpwm_pkg::MODE_CHARGE)
        |-> (r_in_level == '0 && core_res.pwm_period == cpwm_pkg::PERIOD_CHARGE))
        else $error("charge mode with bad level or period");
`endif

endmodule
